[sv/two_hash_bloom_filter_macros.svh]
// Assertion macros for the two-hash bloom filter.
// Used by two_hash_bloom_filter.sv; no other dependencies.
`ifndef TWO_HASH_BLOOM_FILTER_MACROS_SVH
`define TWO_HASH_BLOOM_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked on every rising edge out of reset
`define THBF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thbf assertion failed");

// next-cycle implication
`define THBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thbf assertion failed");

`else

`define THBF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define THBF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/thbf_pkg.sv]
// Shared types and constants for the two-hash bloom filter.
// No dependencies; used by the top level and the bench.
package thbf_pkg;

    localparam int MAX_BYTES  = 4096;
    localparam int ADDR_W     = $clog2(MAX_BYTES);
    localparam int IDX_W      = ADDR_W + 3;          // bit index into the store
    localparam int DIV_W      = IDX_W + 1;           // bit count, up to 8*MAX_BYTES
    localparam int ACC_W      = 64;
    localparam int MULT_W     = 32;
    localparam int FB_W       = 13;
    localparam int CNT_W      = $clog2(ACC_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED_ONE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_TWO     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BYTES = 2'd2;

    localparam logic [MULT_W-1:0] SEED_ONE_RST     = 32'd31;
    localparam logic [MULT_W-1:0] SEED_TWO_RST     = 32'd37;
    localparam logic [FB_W-1:0]   FILTER_BYTES_RST = FB_W'(MAX_BYTES);
    localparam logic [FB_W-1:0]   FB_MAX           = FB_W'(MAX_BYTES);

    localparam logic [0:0] FUNC_QUERY  = 1'b0;
    localparam logic [0:0] FUNC_INSERT = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_DLOAD,
        S_DIV,
        S_RD1,
        S_CHK1,
        S_RD2,
        S_CHK2
    } t_state;

endpackage

[sv/thbf_key_if.sv]
// Key byte channel: valid/ready handshake with one key byte per item.
// No dependencies.
interface thbf_key_if;
    logic              valid;
    logic              ready;
    logic              func;
    logic signed [7:0] key_byte;
    logic              key_last;

    modport source (output valid, func, key_byte, key_last, input ready);
    modport sink   (input valid, func, key_byte, key_last, output ready);
endinterface

[sv/thbf_res_if.sv]
// Result channel: valid/ready handshake carrying the membership answer.
// No dependencies.
interface thbf_res_if;
    logic valid;
    logic ready;
    logic is_member;

    modport source (output valid, is_member, input ready);
    modport sink   (input valid, is_member, output ready);
endinterface

[sv/thbf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module thbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[sv/two_hash_bloom_filter.sv]
// Two-hash bloom filter over byte-streamed keys; uses thbf_pkg, the channel
// interfaces, thbf_ram and the assertion macros.
// A key byte is accepted only while idle and then takes four passes of the
// shared 32x32 multiplier. The last byte adds two 64-step bit-serial modulo
// runs and two reads of the bit store, each written back on an insert.
// Reset: a clearing pass zeroes all 4096 store bytes; no key is taken then.
`include "two_hash_bloom_filter_macros.svh"

module two_hash_bloom_filter
    import thbf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    thbf_key_if.sink              i_key,
    thbf_res_if.source            o_res
);
    t_state              r_state, n_state;
    logic                r_mid, n_mid;
    logic [ACC_W-1:0]    r_acc1, n_acc1, r_acc2, n_acc2;
    logic [MULT_W-1:0]   r_mult1, n_mult1, r_mult2, n_mult2;
    logic [MULT_W-1:0]   r_prod;
    logic [7:0]          r_byte, n_byte;
    logic                r_func, n_func, r_last, n_last;
    logic [MULT_W-1:0]   r_seed1, r_seed2;
    logic [FB_W-1:0]     r_fb;
    logic [DIV_W-1:0]    r_div, n_div;
    logic [ACC_W-1:0]    r_dsh, n_dsh;
    logic [IDX_W-1:0]    r_rem, n_rem;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_hsel, n_hsel;
    logic [IDX_W-1:0]    r_idx1, n_idx1, r_idx2, n_idx2;
    logic                r_b1, n_b1;
    logic                r_ov, n_ov, r_om, n_om;
    logic [ADDR_W-1:0]   r_clr, n_clr;

    logic [MULT_W-1:0]   op_a, op_b, mul_out;
    logic [DIV_W-1:0]    div_t;
    logic [IDX_W-1:0]    rem_next;
    logic [FB_W-1:0]     fb_clamp;
    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [7:0]          ram_wdata, ram_rdata;
    logic                key_acc;

    function automatic logic [ACC_W-1:0] hash_fold(input logic [ACC_W-1:0] acc,
                                                   input logic [MULT_W-1:0] prod);
        logic [ACC_W-1:0] sum;
        logic [ACC_W-1:0] g;
        sum = {acc[ACC_W-5:0], 4'b0000} + {{(ACC_W-MULT_W){prod[MULT_W-1]}}, prod};
        g   = sum & 64'h0000_0000_F000_0000;
        return (sum ^ (g >> 24)) & ~g;
    endfunction

    thbf_ram #(.WIDTH(8), .DEPTH(MAX_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_key.ready   = (r_state == S_IDLE);
    assign key_acc       = i_key.valid && i_key.ready;
    assign o_res.valid   = r_ov;
    assign o_res.is_member = r_om;

    // shared multiplier, low word only
    assign mul_out = MULT_W'(op_a * op_b);

    // one restoring step of the modulo
    assign div_t    = {r_rem, r_dsh[ACC_W-1]};
    assign rem_next = (div_t >= r_div) ? IDX_W'(div_t - r_div) : IDX_W'(div_t);

    assign fb_clamp = (r_fb == '0) ? FB_W'(1) : ((r_fb > FB_MAX) ? FB_MAX : r_fb);

    always_comb begin
        n_state  = r_state;
        n_mid    = r_mid;
        n_acc1   = r_acc1;
        n_acc2   = r_acc2;
        n_mult1  = r_mult1;
        n_mult2  = r_mult2;
        n_byte   = r_byte;
        n_func   = r_func;
        n_last   = r_last;
        n_div    = r_div;
        n_dsh    = r_dsh;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_hsel   = r_hsel;
        n_idx1   = r_idx1;
        n_idx2   = r_idx2;
        n_b1     = r_b1;
        n_ov     = r_ov && !o_res.ready;
        n_om     = r_om;
        n_clr    = r_clr;
        op_a     = {{(MULT_W-8){r_byte[7]}}, r_byte};
        op_b     = r_mult1;
        ram_we    = 1'b0;
        ram_waddr = r_idx1[IDX_W-1:3];
        ram_wdata = ram_rdata | (8'd1 << r_idx1[2:0]);
        ram_re    = 1'b0;
        ram_raddr = r_idx1[IDX_W-1:3];

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == ADDR_W'(MAX_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (key_acc) begin
                    n_byte = i_key.key_byte;
                    n_func = i_key.func;
                    n_last = i_key.key_last;
                    n_mid  = !i_key.key_last;
                    if (!r_mid) begin
                        n_acc1  = '0;
                        n_acc2  = '0;
                        n_mult1 = r_seed1;
                        n_mult2 = r_seed2;
                    end
                    n_div   = {fb_clamp, 3'b000};
                    n_hsel  = 1'b0;
                    n_state = S_M0;
                end
            end
            S_M0: begin
                n_state = S_M1;
            end
            S_M1: begin
                n_acc1  = hash_fold(r_acc1, r_prod);
                op_a    = r_mult1;
                n_state = S_M2;
            end
            S_M2: begin
                n_mult1 = r_prod;
                op_b    = r_mult2;
                n_state = S_M3;
            end
            S_M3: begin
                n_acc2  = hash_fold(r_acc2, r_prod);
                op_a    = r_mult2;
                op_b    = r_mult2;
                n_state = S_M4;
            end
            S_M4: begin
                n_mult2 = r_prod;
                n_state = r_last ? S_DLOAD : S_IDLE;
            end
            S_DLOAD: begin
                n_dsh   = r_hsel ? r_acc2 : r_acc1;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_dsh = {r_dsh[ACC_W-2:0], 1'b0};
                n_rem = rem_next;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ACC_W - 1)) begin
                    if (r_hsel) begin
                        n_idx2  = rem_next;
                        n_state = S_RD1;
                    end else begin
                        n_idx1  = rem_next;
                        n_hsel  = 1'b1;
                        n_state = S_DLOAD;
                    end
                end
            end
            S_RD1: begin
                ram_re  = 1'b1;
                n_state = S_CHK1;
            end
            S_CHK1: begin
                n_b1 = ram_rdata[r_idx1[2:0]];
                if (r_func == FUNC_INSERT) begin
                    ram_we = 1'b1;
                end
                n_state = S_RD2;
            end
            S_RD2: begin
                ram_re    = 1'b1;
                ram_raddr = r_idx2[IDX_W-1:3];
                n_state   = S_CHK2;
            end
            S_CHK2: begin
                ram_waddr = r_idx2[IDX_W-1:3];
                ram_wdata = ram_rdata | (8'd1 << r_idx2[2:0]);
                if (r_func == FUNC_INSERT) begin
                    ram_we  = 1'b1;
                    n_state = S_IDLE;
                end else if (!r_ov || o_res.ready) begin
                    // read data holds while an earlier result is still waiting
                    n_ov    = 1'b1;
                    n_om    = r_b1 && ram_rdata[r_idx2[2:0]];
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_mid   <= 1'b0;
            r_ov    <= 1'b0;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_hsel  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mid   <= n_mid;
            r_ov    <= n_ov;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
            r_hsel  <= n_hsel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc1  <= n_acc1;
        r_acc2  <= n_acc2;
        r_mult1 <= n_mult1;
        r_mult2 <= n_mult2;
        r_prod  <= mul_out;
        r_byte  <= n_byte;
        r_func  <= n_func;
        r_last  <= n_last;
        r_div   <= n_div;
        r_dsh   <= n_dsh;
        r_rem   <= n_rem;
        r_idx1  <= n_idx1;
        r_idx2  <= n_idx2;
        r_b1    <= n_b1;
        r_om    <= n_om;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed1 <= SEED_ONE_RST;
            r_seed2 <= SEED_TWO_RST;
            r_fb    <= FILTER_BYTES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SEED_ONE:     r_seed1 <= i_cfg_data;
                CFG_SEED_TWO:     r_seed2 <= i_cfg_data;
                CFG_FILTER_BYTES: r_fb    <= i_cfg_data[FB_W-1:0];
                default: ;
            endcase
        end
    end

    `THBF_ASSERT_NOW(a_res_from_check, i_clk, i_rst_n, $rose(r_ov), $past(r_state) == S_CHK2)
    `THBF_ASSERT_NOW(a_idx_in_range, i_clk, i_rst_n, r_state == S_RD1, (r_idx1 < r_div) && (r_idx2 < r_div))
    `THBF_ASSERT_NOW(a_div_legal, i_clk, i_rst_n, r_state == S_DIV, (r_div != '0) && (r_div <= DIV_W'(8 * MAX_BYTES)))
    `THBF_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, key_acc, r_state == S_M0)

endmodule

[tb/sv/tb.sv]
// Self-checking bench for two_hash_bloom_filter: streams keys byte by byte,
// predicts membership answers with its own hash and bit store, checks each one.
// Depends on thbf_pkg, thbf_key_if, thbf_res_if and the filter RTL.
module tb;
    import thbf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 200;    // one key byte plus the last-byte back end
    localparam int PHASE_BYTES   = 200;
    localparam int RAND_PHASES   = 9;
    localparam int SAVED_MAX     = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic       func;
        logic [7:0] key_byte;
        logic       key_last;
    } key_item_t;

    typedef struct {
        int          len;
        logic [63:0] bytes;
    } saved_key_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    thbf_key_if key_ch ();
    thbf_res_if res_ch ();

    two_hash_bloom_filter u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_key      (key_ch.sink),
        .o_res      (res_ch.source)
    );

    // pending key bytes and answers still owed by the block
    key_item_t  byte_queue[$];
    logic       membership_q[$];
    saved_key_t saved_keys[$];

    // predictor state
    logic [31:0]     seed_mirror [2] = '{SEED_ONE_RST, SEED_TWO_RST};
    logic [FB_W-1:0] fb_mirror = FILTER_BYTES_RST;
    logic [63:0]     hash_acc [2];
    logic [31:0]     hash_mult [2];
    bit              in_key = 1'b0;
    bit              store_bits [0:8*MAX_BYTES-1];

    bit key_taken = 1'b0;
    int send_gap = 0;
    int stall_left = 0;
    bit sender_quiet = 1'b0;
    bit receiver_quiet = 1'b0;

    int mismatch_count = 0;
    int pushed_bytes = 0;
    int bytes_taken = 0;
    int answers_checked = 0;
    int members_seen = 0;
    int settings_used = 1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("%0t: timeout, %0d bytes queued, %0d answers outstanding",
                 $time, byte_queue.size(), membership_q.size());
        $display("** two_hash_bloom_filter: FAILED **");
        $finish;
    end

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // advance both hashes by one byte; on the last byte insert or look up
    function automatic void predict_byte(key_item_t it);
        logic [31:0] b32;
        logic [31:0] prod;
        logic [63:0] g;
        int          nb;
        int unsigned idx [2];
        bit          hit;
        b32 = {{24{it.key_byte[7]}}, it.key_byte};
        if (!in_key) begin
            for (int h = 0; h < 2; h++) begin
                hash_acc[h]  = '0;
                hash_mult[h] = seed_mirror[h];
            end
            in_key = 1'b1;
        end
        for (int h = 0; h < 2; h++) begin
            prod         = b32 * hash_mult[h];
            hash_acc[h]  = (hash_acc[h] << 4) + {{32{prod[31]}}, prod};
            hash_mult[h] = hash_mult[h] * hash_mult[h];
            g            = hash_acc[h] & 64'hF000_0000;
            hash_acc[h]  = (hash_acc[h] ^ (g >> 24)) & ~g;
        end
        if (!it.key_last) return;
        in_key = 1'b0;
        nb = int'(fb_mirror);
        if (nb < 1) nb = 1;
        if (nb > MAX_BYTES) nb = MAX_BYTES;
        for (int h = 0; h < 2; h++)
            idx[h] = int'(hash_acc[h] % (64'(nb) * 64'd8));
        if (it.func == FUNC_INSERT) begin
            store_bits[idx[0]] = 1'b1;
            store_bits[idx[1]] = 1'b1;
        end else begin
            hit = store_bits[idx[0]] && store_bits[idx[1]];
            membership_q.push_back(hit);
        end
    endfunction

    // byte 0 of the key sits in bits 7:0; bytes past the eighth are random
    function automatic void push_key(logic fn, int len, logic [63:0] bytes, bit mix_func);
        key_item_t it;
        for (int i = 0; i < len; i++) begin
            it.key_byte = (i < 8) ? bytes[8*i +: 8] : 8'($urandom);
            it.key_last = (i == len - 1);
            it.func     = it.key_last ? fn : (mix_func ? 1'($urandom_range(0, 1)) : ~fn);
            byte_queue.push_back(it);
        end
        pushed_bytes += len;
    endfunction

    function automatic void make_random_key();
        saved_key_t k;
        logic       fn;
        int         pick;
        fn = 1'($urandom_range(0, 1));
        if (fn == FUNC_QUERY && saved_keys.size() != 0 && $urandom_range(0, 9) < 6) begin
            k = saved_keys[$urandom_range(0, saved_keys.size() - 1)];
        end else begin
            pick  = $urandom_range(0, 19);
            k.len = (pick < 14) ? $urandom_range(1, 4) :
                    (pick < 19) ? $urandom_range(5, 8) : $urandom_range(9, 32);
            k.bytes = {$urandom, $urandom};
        end
        push_key(fn, k.len, k.bytes, 1'b1);
        if (fn == FUNC_INSERT && k.len <= 8) begin
            saved_keys.push_back(k);
            if (saved_keys.size() > SAVED_MAX) void'(saved_keys.pop_front());
        end
    endfunction

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_SEED_ONE:     seed_mirror[0] = data;
            CFG_SEED_TWO:     seed_mirror[1] = data;
            CFG_FILTER_BYTES: fb_mirror = data[FB_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // inserts give no answer, so give the back end time after the queues drain
    task automatic wait_idle();
        while (byte_queue.size() != 0 || membership_q.size() != 0 || key_ch.valid)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // key side: accept and predict at the rising edge
    always @(posedge i_clk) begin
        key_taken <= i_rst_n && key_ch.valid && key_ch.ready;
        if (i_rst_n && key_ch.valid && key_ch.ready) begin
            predict_byte('{func: key_ch.func, key_byte: key_ch.key_byte,
                           key_last: key_ch.key_last});
            void'(byte_queue.pop_front());
            bytes_taken++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            key_ch.valid    <= 1'b0;
            key_ch.func     <= FUNC_QUERY;
            key_ch.key_byte <= '0;
            key_ch.key_last <= 1'b0;
        end else if (!key_ch.valid || key_taken) begin
            if (send_gap > 0) begin
                key_ch.valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end else if (byte_queue.size() != 0) begin
                key_ch.valid    <= 1'b1;
                key_ch.func     <= byte_queue[0].func;
                key_ch.key_byte <= byte_queue[0].key_byte;
                key_ch.key_last <= byte_queue[0].key_last;
                send_gap        <= pick_gap(sender_quiet);
            end else begin
                key_ch.valid <= 1'b0;
            end
        end
    end

    // result side
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            res_ch.ready <= 1'b1;
            if (!receiver_quiet && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap(1'b0);
        end
    end

    always @(posedge i_clk) begin : res_check
        logic exp_member;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (membership_q.size() == 0) begin
                $display("%0t: is_member %0d arrived with none expected",
                         $time, res_ch.is_member);
                mismatch_count++;
            end else begin
                exp_member = membership_q.pop_front();
                answers_checked++;
                if (res_ch.is_member === 1'b1) members_seen++;
                if (res_ch.is_member !== exp_member) begin
                    $display("%0t: is_member mismatch, expected %0d got %0d",
                             $time, exp_member, res_ch.is_member);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_SEED_ONE;
        cfg_data        = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: extreme bytes, func taken from the last byte only
        push_key(FUNC_INSERT, 3, 64'h00_7F_80, 1'b0);
        push_key(FUNC_QUERY, 3, 64'h00_7F_80, 1'b0);
        push_key(FUNC_QUERY, 1, 64'h55, 1'b0);
        push_key(FUNC_INSERT, 1, 64'hFF, 1'b0);
        push_key(FUNC_QUERY, 1, 64'hFF, 1'b0);
        wait_idle();

        // ignored index, extreme seeds, size zero acts as one byte
        write_cfg(CFG_UNUSED, 32'hFFFF_FFFF);
        write_cfg(CFG_SEED_ONE, 32'h0000_0000);
        write_cfg(CFG_SEED_TWO, 32'hFFFF_FFFF);
        write_cfg(CFG_FILTER_BYTES, 32'd0);
        settings_used++;
        push_key(FUNC_INSERT, 2, 64'h02_01, 1'b0);
        push_key(FUNC_QUERY, 2, 64'h02_01, 1'b0);
        push_key(FUNC_QUERY, 1, 64'h03, 1'b0);
        wait_idle();

        // oversize filter, then config changes in the middle of a key:
        // new seed only for later keys, new size already for this one
        write_cfg(CFG_FILTER_BYTES, 32'd8191);
        settings_used++;
        push_key(FUNC_INSERT, 3, 64'h1E_14_0A, 1'b0);
        byte_queue.push_back('{func: FUNC_INSERT, key_byte: 8'h0A, key_last: 1'b0});
        byte_queue.push_back('{func: FUNC_INSERT, key_byte: 8'h14, key_last: 1'b0});
        pushed_bytes += 2;
        wait_idle();
        write_cfg(CFG_SEED_ONE, 32'd12345);
        write_cfg(CFG_FILTER_BYTES, 32'd1);
        settings_used++;
        byte_queue.push_back('{func: FUNC_QUERY, key_byte: 8'h1E, key_last: 1'b1});
        pushed_bytes += 1;
        push_key(FUNC_QUERY, 3, 64'h1E_14_0A, 1'b0);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            write_cfg(CFG_SEED_ONE, pick_seed());
            write_cfg(CFG_SEED_TWO, pick_seed());
            case (ph)
                0:       write_cfg(CFG_FILTER_BYTES, 32'd1);
                1:       write_cfg(CFG_FILTER_BYTES, 32'd2);
                2:       write_cfg(CFG_FILTER_BYTES, 32'hFFFF_E003);  // upper bits dropped
                3:       write_cfg(CFG_FILTER_BYTES, 32'd16);
                4:       write_cfg(CFG_FILTER_BYTES, $urandom_range(1, 64));
                5:       write_cfg(CFG_FILTER_BYTES, MAX_BYTES);
                6:       write_cfg(CFG_FILTER_BYTES, 32'd8191);
                7:       write_cfg(CFG_FILTER_BYTES, $urandom_range(1, MAX_BYTES));
                default: write_cfg(CFG_FILTER_BYTES, 32'd5000);
            endcase
            settings_used++;
            sender_quiet   = (ph % 4 == 2);
            receiver_quiet = sender_quiet;
            while (pushed_bytes < 21 + (ph + 1) * PHASE_BYTES)
                make_random_key();
        end

        wait_idle();
        $display("Sent %0d key bytes under %0d filter settings (sizes 0..8191 written).",
                 bytes_taken, settings_used);
        $display("Checked %0d membership answers, %0d of them positive.",
                 answers_checked, members_seen);
        if (mismatch_count == 0) begin
            $display("** two_hash_bloom_filter: PASSED **");
        end else begin
            $display("** two_hash_bloom_filter: FAILED **");
        end
        $finish;
    end

endmodule
